/* rtl/record_string_hash_combiner_assert.svh */
// ---------------------------------------------------------------------------
// Record string hash combiner assertion macros
// Concurrent assertion wrappers; they compile to nothing under SYNTHESIS.
// ---------------------------------------------------------------------------
`ifndef RECORD_STRING_HASH_COMBINER_ASSERT_SVH
`define RECORD_STRING_HASH_COMBINER_ASSERT_SVH

`ifndef SYNTHESIS

// Condition must hold at every clock edge outside reset.
`define RSHC_ASSERT_ALWAYS(label, clk, rst, cond) \
   label: assert property (@(posedge clk) disable iff (rst) (cond)) \
      else $error("assertion failed");

// Consequent must hold in the cycle after the antecedent.
`define RSHC_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");

`else

`define RSHC_ASSERT_ALWAYS(label, clk, rst, cond)
`define RSHC_ASSERT_NEXT(label, clk, rst, ante, cons)

`endif

`endif

/* rtl/rshc_pkg.sv */
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// rshc_pkg
// Shared types and constants for the record string hash combiner.
// ---------------------------------------------------------------------------
package rshc_pkg;

   localparam int unsigned WC_W    = 10;
   localparam int unsigned BYTES_W = WC_W + 2;

   localparam logic [31:0] MAX_WORDS = 32'd1023;

   localparam logic        FUNC_HEADER = 1'b0;
   localparam logic        FUNC_BYTE   = 1'b1;

   localparam logic [31:0] HASH_SEED = 32'd5381;

   localparam logic [15:0] FLAG_FIELD_A = 16'h0002;
   localparam logic [15:0] FLAG_FIELD_B = 16'h0004;
   localparam logic [15:0] FLAG_FIELD_C = 16'h0008;
   localparam logic [15:0] FLAG_FIELD_D = 16'h0010;
   localparam logic [15:0] FLAG_FIELD_E = 16'h0020;
   localparam logic [15:0] FLAG_STRING  = 16'h0040;
   localparam logic [15:0] FLAG_MIX_EN  = 16'h0100;
   localparam logic [15:0] FLAG_MIX_SRC = 16'h8000;

   localparam logic [31:0] MIX_MASK_HI  = 32'h6000_0000;
   localparam logic [31:0] MIX_MASK_MID = 32'h0030_0000;

   typedef struct packed {
      logic [31:0]        running_hash;
      logic [BYTES_W-1:0] bytes_left;
      logic [31:0]        side_term;
      logic               record_open;
   } state_type;

   typedef struct packed {
      logic        emit;
      logic [31:0] hash;
   } result_type;

endpackage

/* rtl/record_string_hash_combiner.sv */
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// record_string_hash_combiner
// Combines an sdbm-style (x65599) string hash with header field terms.
// ---------------------------------------------------------------------------
//
//   Channel | Direction | Handshake            | Payload
//   --------+-----------+----------------------+-----------------------------
//   req     | in        | req_valid/req_stall  | func, flags, fields, byte
//   rsp     | out       | rsp_valid/rsp_stall  | hash
//
// A new transaction on req can be accepted in every cycle, limited only by
// the single result register. A result is registered and appears on rsp
// in the cycle after the transaction that completes it.
// Reset is synchronous and active high; it closes any open record.
// req_stall is raised only while a result waits in the output register and
// rsp_stall holds it there.
//
// A header transaction computes the side term from the flag word and fields.
// When string hashing is enabled and words are due, the following byte
// transactions fold into the running hash, one per cycle unless req_stall
// holds them, and the last one produces the result. Otherwise the header
// produces its result directly. A header always discards any record still
// open. Byte transactions with no open record are dropped.
// ---------------------------------------------------------------------------
`include "record_string_hash_combiner_assert.svh"

module record_string_hash_combiner (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_valid,
   output logic                        req_stall,
   input  logic                        req_func,
   input  logic [15:0]                 req_flags,
   input  logic                        req_has_string,
   input  logic [rshc_pkg::WC_W-1:0]   req_word_count,
   input  logic [15:0]                 req_field_a,
   input  logic signed [15:0]          req_field_b,
   input  logic signed [15:0]          req_field_c,
   input  logic [15:0]                 req_field_d,
   input  logic [15:0]                 req_field_e,
   input  logic [7:0]                  req_data_byte,
   output logic                        rsp_valid,
   input  logic                        rsp_stall,
   output logic [31:0]                 rsp_hash
);

   rshc_pkg::state_type  state_ff;
   rshc_pkg::state_type  state_in;
   rshc_pkg::result_type step_res;
   logic [31:0]          side_term;
   logic                 rsp_valid_ff;
   logic                 rsp_valid_in;
   logic [31:0]          rsp_hash_ff;
   logic [31:0]          rsp_hash_in;
   logic                 req_accept;
   logic                 hdr_accept;
   logic                 stray_accept;

   // The input side waits only while a result is held by the consumer.
   assign req_stall  = rsp_valid_ff && rsp_stall;
   assign req_accept = req_valid && !req_stall;

   // Accepted headers, and accepted bytes that arrive with no record open.
   assign hdr_accept   = req_accept && (req_func == rshc_pkg::FUNC_HEADER);
   assign stray_accept = req_accept && (req_func == rshc_pkg::FUNC_BYTE)
                       && !state_ff.record_open;

   rshc_side u_side (
      .flags     (req_flags),
      .field_a   (req_field_a),
      .field_b   (req_field_b),
      .field_c   (req_field_c),
      .field_d   (req_field_d),
      .field_e   (req_field_e),
      .side_term (side_term)
   );

   rshc_step u_step (
      .cur        (state_ff),
      .func       (req_func),
      .flags      (req_flags),
      .has_string (req_has_string),
      .word_count (req_word_count),
      .data_byte  (req_data_byte),
      .side_term  (side_term),
      .nxt        (state_in),
      .res        (step_res)
   );

   // The result register loads whenever a transaction completes a record;
   // acceptance guarantees that it is empty or being emptied this cycle.
   always_comb begin
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_hash_in  = rsp_hash_ff;
      if (req_accept && step_res.emit) begin
         rsp_valid_in = 1'b1;
         rsp_hash_in  = step_res.hash;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (req_accept) begin
            state_ff <= state_in;
         end
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_hash_ff <= rsp_hash_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_hash  = rsp_hash_ff;

   // An open record always has bytes still due, and a closed one has none.
   `RSHC_ASSERT_ALWAYS(a_open_bytes, clock, reset, state_ff.record_open == |state_ff.bytes_left)
   // The input side is held only while a result is waiting.
   `RSHC_ASSERT_ALWAYS(a_stall_only_when_full, clock, reset, !req_stall || rsp_valid)
   // A byte with no open record never produces a result.
   `RSHC_ASSERT_NEXT(a_stray_byte_silent, clock, reset, stray_accept, !rsp_valid)
   // A header always loads its side term into the record state.
   `RSHC_ASSERT_NEXT(a_hdr_side, clock, reset, hdr_accept, state_ff.side_term == $past(side_term))

endmodule

/* rtl/rshc_side.sv */
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// rshc_side
// Builds the side term of a header: gated field contributions and flag mix.
// ---------------------------------------------------------------------------
module rshc_side (
   input  logic [15:0]        flags,
   input  logic [15:0]        field_a,
   input  logic signed [15:0] field_b,
   input  logic signed [15:0] field_c,
   input  logic [15:0]        field_d,
   input  logic [15:0]        field_e,
   output logic [31:0]        side_term
);

   logic [31:0] f32;
   logic [31:0] acc;
   logic [31:0] mix;
   logic        mix_bit;

   always_comb begin
      f32 = {16'h0000, flags};
      acc = 32'h0;
      if ((flags & rshc_pkg::FLAG_FIELD_A) != 16'h0) begin
         acc = acc ^ f32 ^ f32 ^ {16'h0000, field_a};
      end
      if ((flags & rshc_pkg::FLAG_FIELD_B) != 16'h0) begin
         acc = acc ^ ({{16{field_b[15]}}, field_b} << 8);
      end
      if ((flags & rshc_pkg::FLAG_FIELD_C) != 16'h0) begin
         acc = acc ^ ({{16{field_c[15]}}, field_c} << 12);
      end
      if ((flags & rshc_pkg::FLAG_FIELD_D) != 16'h0) begin
         acc = acc ^ ({16'h0000, field_d} << 16);
      end
      if ((flags & rshc_pkg::FLAG_FIELD_E) != 16'h0) begin
         acc = acc ^ ({16'h0000, field_e} << 18);
      end
      mix_bit = ((flags & rshc_pkg::FLAG_MIX_EN) != 16'h0) &&
                ((flags & rshc_pkg::FLAG_MIX_SRC) != 16'h0);
      // Rotations of the zero-extended flag word by 24, 9 and 31.
      mix = ({f32[7:0], f32[31:8]} & rshc_pkg::MIX_MASK_HI)
          | {f32[22:0], f32[31:23]}
          | {31'h0, mix_bit};
      mix = mix ^ ({f32[0], f32[31:1]} & rshc_pkg::MIX_MASK_MID);
      side_term = acc ^ mix;
   end

endmodule

/* rtl/rshc_step.sv */
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// rshc_step
// Next-state and result logic for one accepted header or string byte.
// ---------------------------------------------------------------------------
module rshc_step (
   input  rshc_pkg::state_type              cur,
   input  logic                             func,
   input  logic [15:0]                      flags,
   input  logic                             has_string,
   input  logic [rshc_pkg::WC_W-1:0]        word_count,
   input  logic [7:0]                       data_byte,
   input  logic [31:0]                      side_term,
   output rshc_pkg::state_type              nxt,
   output rshc_pkg::result_type             res
);

   logic [rshc_pkg::WC_W-1:0]    sat_words;
   logic [31:0]                  mult_hash;
   logic [rshc_pkg::BYTES_W-1:0] dec_left;

   always_comb begin
      if ({22'h0, word_count} > rshc_pkg::MAX_WORDS) begin
         sat_words = rshc_pkg::MAX_WORDS[rshc_pkg::WC_W-1:0];
      end else begin
         sat_words = word_count;
      end
      // h * 65599 = (h << 16) + (h << 6) - h
      mult_hash = (cur.running_hash << 16) + (cur.running_hash << 6)
                - cur.running_hash + {24'h0, data_byte};
      dec_left  = cur.bytes_left - rshc_pkg::BYTES_W'(1);

      nxt = cur;
      res = '0;
      if (func == rshc_pkg::FUNC_HEADER) begin
         nxt.record_open  = 1'b0;
         nxt.bytes_left   = '0;
         nxt.running_hash = 32'h0;
         nxt.side_term    = side_term;
         if (((flags & rshc_pkg::FLAG_STRING) != 16'h0) && has_string) begin
            nxt.running_hash = rshc_pkg::HASH_SEED;
            if (sat_words == '0) begin
               res.emit = 1'b1;
               res.hash = rshc_pkg::HASH_SEED ^ side_term;
            end else begin
               nxt.bytes_left  = {sat_words, 2'b00};
               nxt.record_open = 1'b1;
            end
         end else begin
            res.emit = 1'b1;
            res.hash = side_term;
         end
      end else if (cur.record_open) begin
         nxt.running_hash = mult_hash;
         nxt.bytes_left   = dec_left;
         if (dec_left == '0) begin
            nxt.record_open = 1'b0;
            res.emit        = 1'b1;
            res.hash        = mult_hash ^ cur.side_term;
         end
      end
   end

endmodule
